// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the timer bank RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge while out of reset.
`define PSTB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define PSTB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/pstb_pkg.sv =====
// Package for the periodic soft timer bank: sizes, kind codes and transaction types.
// No dependencies.
package pstb_pkg;

    localparam int NUM_TIMERS     = 4;
    localparam int COUNT_WIDTH    = 16;

    localparam int KIND_W         = 2;
    localparam int TIMER_ID_W     = 3;
    localparam int PERIOD_W       = 16;
    localparam int EXPIRED_MASK_W = 4;
    localparam int HIT_W          = (NUM_TIMERS > EXPIRED_MASK_W) ? NUM_TIMERS : EXPIRED_MASK_W;

    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_KILL  = 2'd2;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [TIMER_ID_W-1:0] timer_id;
        logic [PERIOD_W-1:0]   period_ticks;
    } item_t;

    typedef struct packed {
        logic [EXPIRED_MASK_W-1:0] expired_mask;
        logic                      bad_id;
    } result_t;

endpackage

// ===== hw/rtl/pstb_in_stage.sv =====
// Input register of the timer bank: holds one accepted transaction.
// Depends on pstb_pkg.
module pstb_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  logic           drain,
    input  pstb_pkg::item_t item_in,
    output logic           valid,
    output pstb_pkg::item_t item_out
);
    import pstb_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (drain)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign valid    = valid_reg;
    assign item_out = item_reg;

endmodule

// ===== hw/rtl/pstb_timer_bank.sv =====
// Timer state and per-transaction update: tick, start and kill of the countdown timers.
// Depends on pstb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pstb_timer_bank (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             apply,
    input  pstb_pkg::item_t   item,
    output pstb_pkg::result_t result
);
    import pstb_pkg::*;

    count_t cnt_reg  [NUM_TIMERS];
    count_t cnt_next [NUM_TIMERS];
    count_t rel_reg  [NUM_TIMERS];
    count_t rel_next [NUM_TIMERS];
    logic [HIT_W-1:0] hit;
    logic   id_known;
    logic   err;
    count_t load_val;

    always_comb
    begin
        id_known = (32'(item.timer_id) < NUM_TIMERS);
        load_val = (item.kind == KIND_START) ? COUNT_WIDTH'(item.period_ticks) : '0;
        hit      = '0;
        err      = 1'b0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            cnt_next[i] = cnt_reg[i];
            rel_next[i] = rel_reg[i];
        end
        unique case (item.kind)
            KIND_TICK:
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (cnt_reg[i] == COUNT_WIDTH'(1))
                    begin
                        cnt_next[i] = rel_reg[i];
                        hit[i]      = 1'b1;
                    end
                    else if (cnt_reg[i] != '0)
                    begin
                        cnt_next[i] = cnt_reg[i] - COUNT_WIDTH'(1);
                    end
                end
            end
            KIND_START, KIND_KILL:
            begin
                if (id_known)
                begin
                    for (int i = 0; i < NUM_TIMERS; i++)
                    begin
                        if (32'(item.timer_id) == i)
                        begin
                            cnt_next[i] = load_val;
                            rel_next[i] = load_val;
                        end
                    end
                end
                else
                begin
                    err = 1'b1;
                end
            end
            default:
            begin
                // drop unused kind
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                cnt_reg[i] <= '0;
                rel_reg[i] <= '0;
            end
        end
        else if (apply)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
                rel_reg[i] <= rel_next[i];
            end
        end
    end

    assign result.expired_mask = hit[EXPIRED_MASK_W-1:0];
    assign result.bad_id       = err;

    `PSTB_ASSERT(a_err_excl_expiry, !(err && (hit != '0)), "error with expiry")

    for (genvar g = 0; g < NUM_TIMERS; g++)
    begin : g_chk
        `PSTB_ASSERT(a_cnt_le_reload, cnt_reg[g] <= rel_reg[g], "counter above reload")
        `PSTB_ASSERT(a_idle_zero, (cnt_reg[g] == '0) |-> (rel_reg[g] == '0), "stray reload")
    end

endmodule

// ===== hw/rtl/pstb_out_stage.sv =====
// Result register of the timer bank: holds one result transaction until taken.
// Depends on pstb_pkg.
module pstb_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             taken,
    input  pstb_pkg::result_t res_in,
    output logic             valid,
    output pstb_pkg::result_t res_out
);
    import pstb_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (taken)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign valid   = valid_reg;
    assign res_out = res_reg;

endmodule

// ===== hw/rtl/periodic_soft_timer_bank_top.sv =====
// Top level of the periodic soft timer bank: input register, timer state, result register.
// Depends on pstb_pkg, pstb_in_stage, pstb_timer_bank, pstb_out_stage, assert_macros.svh.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------
//   input   | in_valid / in_ready | kind, timer_id, period_ticks
//   output  | out_valid/out_ready | expired_mask, bad_id
//
// One transaction per cycle unless the output stalls; the result loads as the input drains.
// The latency is set by the input register and the result register around the timer update.
// Reset clears all counters and reload values and empties both registers.
// A stalled output holds the result; the input register still takes one more transaction.
`include "assert_macros.svh"

module periodic_soft_timer_bank_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [pstb_pkg::KIND_W-1:0]            kind,
    input  logic [pstb_pkg::TIMER_ID_W-1:0]        timer_id,
    input  logic [pstb_pkg::PERIOD_W-1:0]          period_ticks,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [pstb_pkg::EXPIRED_MASK_W-1:0]    expired_mask,
    output logic                                   bad_id
);
    import pstb_pkg::*;

    item_t   item_in;
    item_t   item_s1;
    result_t res_s1;
    result_t res_out;
    logic    s1_valid;
    logic    advance;
    logic    in_load;

    assign item_in.kind         = kind;
    assign item_in.timer_id     = timer_id;
    assign item_in.period_ticks = period_ticks;

    assign advance  = s1_valid && (!out_valid || out_ready);
    assign in_ready = !s1_valid || advance;
    assign in_load  = in_valid && in_ready;

    pstb_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_load),
        .drain    (advance),
        .item_in  (item_in),
        .valid    (s1_valid),
        .item_out (item_s1)
    );

    pstb_timer_bank u_bank (
        .clk    (clk),
        .rst_n  (rst_n),
        .apply  (advance),
        .item   (item_s1),
        .result (res_s1)
    );

    pstb_out_stage u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (advance),
        .taken   (out_valid && out_ready),
        .res_in  (res_s1),
        .valid   (out_valid),
        .res_out (res_out)
    );

    assign expired_mask = res_out.expired_mask;
    assign bad_id       = res_out.bad_id;

    `PSTB_ASSERT(a_stall, !in_ready |-> (s1_valid && out_valid && !out_ready), "bad stall")
    `PSTB_ASSERT(a_advance_fills_out, advance |=> out_valid, "result lost")

endmodule

// ===== dv/tb.sv =====
// Testbench for periodic_soft_timer_bank_top: directed and random tick, start, kill and unused-kind traffic.
// Predicts expiry masks and id errors in a scoreboard class and checks every result in order.
// Depends on pstb_pkg and the RTL of the block.
module tb;
    import pstb_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 700;
    localparam int STALL_LIMIT    = 4000;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int DRAIN_CYCLES   = 10;
    localparam int MAX_REPORTS    = 10;
    localparam int TIMER_IDX_W    = $clog2(NUM_TIMERS);

    class expiry_scoreboard;
        count_t down_cnt[NUM_TIMERS];
        count_t reload_val[NUM_TIMERS];
        result_t expected_results[$];
        int unsigned mismatches;

        function new();
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                down_cnt[i] = '0;
                reload_val[i] = '0;
            end
            mismatches = 0;
        endfunction

        function void note_command(logic [KIND_W-1:0] k, logic [TIMER_ID_W-1:0] id,
                                   logic [PERIOD_W-1:0] p);
            result_t res;
            logic [TIMER_IDX_W-1:0] idx;
            res = '0;
            idx = id[TIMER_IDX_W-1:0];
            if (k == KIND_TICK)
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (down_cnt[i] != '0)
                    begin
                        down_cnt[i] = down_cnt[i] - 1'b1;
                        if (down_cnt[i] == '0)
                        begin
                            down_cnt[i] = reload_val[i];
                            if (i < EXPIRED_MASK_W)
                                res.expired_mask[i] = 1'b1;
                        end
                    end
                end
            end
            else if (k == KIND_START || k == KIND_KILL)
            begin
                if (id < NUM_TIMERS)
                begin
                    down_cnt[idx] = (k == KIND_START) ? count_t'(p) : '0;
                    reload_val[idx] = down_cnt[idx];
                end
                else
                    res.bad_id = 1'b1;
            end
            expected_results.push_back(res);
        endfunction

        function void check_result(logic [EXPIRED_MASK_W-1:0] mask, logic err);
            result_t exp_res;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: expired_mask=%h bad_id=%b", mask, err);
                return;
            end
            exp_res = expected_results.pop_front();
            if (mask !== exp_res.expired_mask || err !== exp_res.bad_id)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: expired_mask exp %h got %h, bad_id exp %b got %b",
                             exp_res.expired_mask, mask, exp_res.bad_id, err);
            end
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [KIND_W-1:0]         kind = '0;
    logic [TIMER_ID_W-1:0]     timer_id = '0;
    logic [PERIOD_W-1:0]       period_ticks = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [EXPIRED_MASK_W-1:0] expired_mask;
    logic                      bad_id;

    logic idle_en = 1'b1;
    logic hold_req = 1'b0;
    expiry_scoreboard sb = new();

    periodic_soft_timer_bank_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .timer_id     (timer_id),
        .period_ticks (period_ticks),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .expired_mask (expired_mask),
        .bad_id       (bad_id)
    );

    always #5 clk = ~clk;

    task automatic send_item(input logic [KIND_W-1:0] k, input logic [TIMER_ID_W-1:0] id,
                             input logic [PERIOD_W-1:0] p);
        @(negedge clk);
        while (idle_en && $urandom_range(99) < 12)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        kind = k;
        timer_id = id;
        period_ticks = p;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_command(k, id, p);
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        send_item(KIND_TICK, 3'd0, 16'h0000);
        send_item(KIND_START, 3'd0, 16'd1);
        send_item(KIND_START, 3'd1, 16'd2);
        send_item(KIND_START, 3'd2, 16'd0);
        send_item(KIND_START, 3'd3, 16'hFFFF);
        repeat (3) send_item(KIND_TICK, 3'd7, 16'hFFFF);
        send_item(KIND_START, 3'd4, 16'hFFFF);
        send_item(KIND_KILL, 3'd7, 16'hFFFF);
        send_item(KIND_UNUSED, 3'd7, 16'hFFFF);
        send_item(KIND_UNUSED, 3'd1, 16'h0000);
        send_item(KIND_KILL, 3'd0, 16'h0000);
        send_item(KIND_TICK, 3'd0, 16'h0000);
        send_item(KIND_KILL, 3'd3, 16'h5A5A);
        for (int i = 0; i < NUM_TIMERS; i++)
            send_item(KIND_START, TIMER_ID_W'(i), 16'd1);
        repeat (2) send_item(KIND_TICK, 3'd0, 16'h0000);
        send_item(KIND_START, 3'd2, 16'h8000);
        send_item(KIND_KILL, 3'd2, 16'h0000);
    endtask

    task automatic run_random();
        int unsigned sel;
        int unsigned psel;
        logic [KIND_W-1:0] k;
        logic [TIMER_ID_W-1:0] id;
        logic [PERIOD_W-1:0] p;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            idle_en = !(n >= 200 && n < 350);
            if (n == 400)
                hold_req = 1'b1;
            if (n == 550)
                wait_for_drain();
            sel = $urandom_range(99);
            if (sel < 58)
                k = KIND_TICK;
            else if (sel < 80)
                k = KIND_START;
            else if (sel < 94)
                k = KIND_KILL;
            else
                k = KIND_UNUSED;
            id = ($urandom_range(9) == 0) ? TIMER_ID_W'($urandom_range(7, 4))
                                          : TIMER_ID_W'($urandom_range(NUM_TIMERS - 1, 0));
            psel = $urandom_range(19);
            if (k == KIND_TICK || psel == 1)
                p = PERIOD_W'($urandom_range(65535));
            else if (psel == 0)
                p = '0;
            else if (psel == 2)
                p = 16'hFFFF - PERIOD_W'($urandom_range(3));
            else
                p = PERIOD_W'($urandom_range(12, 1));
            send_item(k, id, p);
        end
    endtask

    initial
    begin
        logic hold_done;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready = 1'b0;
                repeat (HOLDOFF_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else
                out_ready = idle_en ? ($urandom_range(99) >= 12) : 1'b1;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result(expired_mask, bad_id);
        end
    end

    initial
    begin
        int unsigned stall_cnt;
        stall_cnt = 0;
        while (stall_cnt < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cnt = 0;
            else
                stall_cnt++;
        end
        $display("** periodic_soft_timer_bank_top: FAILED **");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        run_directed();
        run_random();
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("** periodic_soft_timer_bank_top: PASSED **");
        else
            $display("** periodic_soft_timer_bank_top: FAILED **");
        $finish;
    end
endmodule

// ===== periodic_soft_timer_bank_top.f =====
+incdir+hw/rtl
hw/rtl/pstb_pkg.sv
hw/rtl/pstb_in_stage.sv
hw/rtl/pstb_timer_bank.sv
hw/rtl/pstb_out_stage.sv
hw/rtl/periodic_soft_timer_bank_top.sv
dv/tb.sv
